[hdl/sbdd_pkg.sv]
// ----------------------------------------------------------------------------
// sbdd_pkg
// shared types and constants for the signed binary to decimal digit converter
// ----------------------------------------------------------------------------
package sbdd_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int MAX_DIGITS_DEF  = 19;

    // fixed field widths of a result item
    localparam int DIGIT_W     = 4;
    localparam int COUNT_W     = 5;
    localparam int OUT_TDATA_W = 16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } t_state;

    // sequencer controls for the conversion datapath
    typedef struct packed {
        logic load;
        logic step;
    } t_conv_ctl;

endpackage

[hdl/sbdd_dabble.sv]
// ----------------------------------------------------------------------------
// sbdd_dabble
// sign/magnitude split and bit-serial shift-add-3 conversion with digit count
// ----------------------------------------------------------------------------
module sbdd_dabble #(
    parameter int VALUE_WIDTH = sbdd_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_DIGITS  = sbdd_pkg::MAX_DIGITS_DEF
) (
    input  logic                                      i_clk,
    input  sbdd_pkg::t_conv_ctl                       i_ctl,
    input  logic [VALUE_WIDTH-1:0]                    i_value,
    output logic [MAX_DIGITS*sbdd_pkg::DIGIT_W-1:0]   o_bcd,
    output logic [sbdd_pkg::COUNT_W-1:0]              o_count,
    output logic                                      o_negative
);
    import sbdd_pkg::*;

    localparam int BCD_W = MAX_DIGITS * DIGIT_W;
    localparam int IW    = $clog2(MAX_DIGITS);

    logic [VALUE_WIDTH-1:0] r_mag;
    logic [BCD_W-1:0]       r_bcd;
    logic [COUNT_W-1:0]     r_cnt;
    logic                   r_neg;

    logic [BCD_W-1:0]       w_adj;
    logic [BCD_W-1:0]       n_bcd;
    logic [DIGIT_W-1:0]     w_new_dig [MAX_DIGITS];
    logic                   w_grow;

    function automatic logic [DIGIT_W-1:0] f_add3(input logic [DIGIT_W-1:0] d);
        return (d >= DIGIT_W'(5)) ? d + DIGIT_W'(3) : d;
    endfunction

    // add 3 to every digit of 5 or more, then shift in the next magnitude bit
    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            w_adj[i*DIGIT_W +: DIGIT_W] = f_add3(r_bcd[i*DIGIT_W +: DIGIT_W]);
        end
        n_bcd = {w_adj[BCD_W-2:0], r_mag[VALUE_WIDTH-1]};
        for (int i = 0; i < MAX_DIGITS; i++) begin
            w_new_dig[i] = n_bcd[i*DIGIT_W +: DIGIT_W];
        end
    end

    // each step maps the value v to at most 2v + 1, so it gains at most one digit
    always_comb begin
        w_grow = 1'b0;
        if (r_cnt < COUNT_W'(MAX_DIGITS)) begin
            w_grow = (w_new_dig[r_cnt[IW-1:0]] != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_neg <= i_value[VALUE_WIDTH-1];
            r_mag <= i_value[VALUE_WIDTH-1] ? (~i_value + VALUE_WIDTH'(1)) : i_value;
            r_bcd <= '0;
            r_cnt <= COUNT_W'(1);
        end else if (i_ctl.step) begin
            r_mag <= {r_mag[VALUE_WIDTH-2:0], 1'b0};
            r_bcd <= n_bcd;
            if (w_grow) begin
                r_cnt <= r_cnt + COUNT_W'(1);
            end
        end
    end

    assign o_bcd      = r_bcd;
    assign o_count    = r_cnt;
    assign o_negative = r_neg;

endmodule

[hdl/signed_binary_to_decimal_digits.sv]
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_digits
// signed integer to decimal digits, most significant digit first
// ----------------------------------------------------------------------------
// Takes one signed two's-complement integer of VALUE_WIDTH bits and returns
// its decimal magnitude as a run of items, one digit each, most significant
// first and without leading zeros; zero gives the single digit 0. Every item
// also carries the sign, the digit count of the run, and tlast on the least
// significant digit. The most negative input is converted exactly. The block
// handles one integer at a time: it takes the integer, runs shift-add-3 (one
// magnitude bit per cycle through the BCD shift register), then emits the
// digits at the output, each held until it is taken. If the magnitude has more
// than MAX_DIGITS digits only the low MAX_DIGITS digits are returned and
// digit_count reads MAX_DIGITS.
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_digits #(
    parameter int VALUE_WIDTH = sbdd_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_DIGITS  = sbdd_pkg::MAX_DIGITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input items
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]      s_axis_tdata,   // value
    // result items
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [sbdd_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,   // digit, negative, digit_count
    output logic                                  m_axis_tlast    // last
);
    import sbdd_pkg::*;

    localparam int BCD_W = MAX_DIGITS * DIGIT_W;
    localparam int IW    = $clog2(MAX_DIGITS);
    localparam int BW    = $clog2(VALUE_WIDTH);

    t_state             r_state;
    t_state             n_state;
    logic [BW-1:0]      r_bit;
    logic [BW-1:0]      n_bit;
    logic [IW-1:0]      r_pos;
    logic [IW-1:0]      n_pos;
    t_conv_ctl          w_ctl;

    logic [BCD_W-1:0]   w_bcd;
    logic [COUNT_W-1:0] w_count;
    logic               w_negative;
    logic [DIGIT_W-1:0] w_digits [MAX_DIGITS];
    logic [IW-1:0]      w_top;
    logic [IW-1:0]      w_sel;
    logic               w_last;

    // conversion datapath
    sbdd_dabble #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) u_dabble (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .i_value    (s_axis_tdata[VALUE_WIDTH-1:0]),
        .o_bcd      (w_bcd),
        .o_count    (w_count),
        .o_negative (w_negative)
    );

    // digit view of the bcd register
    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            w_digits[i] = w_bcd[i*DIGIT_W +: DIGIT_W];
        end
    end

    // r_pos counts emitted digits; the most significant one sits at count - 1
    assign w_top  = IW'(w_count - COUNT_W'(1));
    assign w_sel  = w_top - r_pos;
    assign w_last = (r_pos == w_top);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_bit   <= '0;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            r_bit   <= n_bit;
            r_pos   <= n_pos;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_bit         = r_bit;
        n_pos         = r_pos;
        w_ctl         = '0;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    w_ctl.load = 1'b1;
                    n_bit      = '0;
                    n_state    = ST_CONV;
                end
            end
            ST_CONV: begin
                // one magnitude bit per cycle
                w_ctl.step = 1'b1;
                n_bit      = r_bit + BW'(1);
                if (r_bit == BW'(VALUE_WIDTH - 1)) begin
                    n_pos   = '0;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready) begin
                    if (w_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_pos = r_pos + IW'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // packing from the lowest bit: digit, negative, digit_count, zero fill
    assign m_axis_tdata = {{(OUT_TDATA_W - DIGIT_W - 1 - COUNT_W){1'b0}},
                           w_count, w_negative, w_digits[w_sel]};
    assign m_axis_tlast = w_last;

endmodule
